// ===== rtl/xfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// xfcp_pkg: shared types and constants of the framed command parser
// Field widths, register indexes, status and action codes, and the records
// that pass between the front end, the frame queue and the back end.
// ----------------------------------------------------------------------------
package xfcp_pkg;

   localparam int BYTE_W    = 8;
   localparam int TIME_W    = 32;
   localparam int TMO_W     = 16;
   localparam int STATUS_W  = 2;
   localparam int ACTION_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam int MAX_DATA_DEFAULT = 32;
   localparam int QUEUE_DEPTH      = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_BYTE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_MS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_GREEN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_YELLOW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_RED    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_OFF    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_BUZZER = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_SUM   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SHORT_BUZ = 2'd3;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_GREEN  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_YELLOW = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_RED    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_OFF    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_BUZZER = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_NONE   = 3'd5;

   typedef struct packed {
      logic [BYTE_W-1:0] start_byte;
      logic [TMO_W-1:0]  timeout_ms;
      logic [BYTE_W-1:0] code_green;
      logic [BYTE_W-1:0] code_yellow;
      logic [BYTE_W-1:0] code_red;
      logic [BYTE_W-1:0] code_off;
      logic [BYTE_W-1:0] code_buzzer;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      start_byte:  8'hAA,
      timeout_ms:  16'd50,
      code_green:  8'd1,
      code_yellow: 8'd2,
      code_red:    8'd3,
      code_off:    8'd4,
      code_buzzer: 8'd5
   };

   // one complete frame, as classified by the front end
   typedef struct packed {
      logic              sum_ok;
      logic              two_data;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] first_data;
      logic [BYTE_W-1:0] second_data;
   } frame_type;

endpackage

// ===== rtl/xfcp_if.sv =====
// ----------------------------------------------------------------------------
// xfcp_if: channel interfaces of the framed command parser
// Receive byte channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface xfcp_req_if;
   logic                        valid;
   logic                        ready;
   logic [xfcp_pkg::BYTE_W-1:0] rx_byte;
   logic [xfcp_pkg::TIME_W-1:0] now_ms;

   modport source (output valid, rx_byte, now_ms, input ready);
   modport sink   (input valid, rx_byte, now_ms, output ready);
endinterface

interface xfcp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [xfcp_pkg::STATUS_W-1:0] status;
   logic [xfcp_pkg::ACTION_W-1:0] action;
   logic [xfcp_pkg::BYTE_W-1:0]   volume;
   logic [xfcp_pkg::BYTE_W-1:0]   duration;

   modport source (output valid, status, action, volume, duration, input ready);
   modport sink   (input valid, status, action, volume, duration, output ready);
endinterface

interface xfcp_csr_if;
   logic                           valid;
   logic                           ready;
   logic [xfcp_pkg::CSR_IDX_W-1:0] index;
   logic [xfcp_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/xfcp_front.sv =====
// ----------------------------------------------------------------------------
// xfcp_front: byte-level frame tracker
// Applies the inter-byte timeout, walks the frame phases, keeps the running
// XOR and hands each completed frame to the queue.
// ----------------------------------------------------------------------------
module xfcp_front #(
   parameter int MAX_DATA = xfcp_pkg::MAX_DATA_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  xfcp_pkg::cfg_type             cfg,
   input  logic                          byte_valid,
   output logic                          byte_ready,
   input  logic [xfcp_pkg::BYTE_W-1:0]   rx_byte,
   input  logic [xfcp_pkg::TIME_W-1:0]   now_ms,
   input  logic                          queue_full,
   output logic                          frame_push,
   output xfcp_pkg::frame_type           frame
);
   import xfcp_pkg::*;

   localparam int IDX_W = $clog2(MAX_DATA + 1);

   localparam logic [2:0] PH_WAIT = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_SUM  = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] command_ff, command_in;
   logic [IDX_W-1:0]  length_ff, length_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] first_ff, first_in;
   logic [BYTE_W-1:0] second_ff, second_in;
   logic [TIME_W-1:0] last_time_ff;

   logic              accept;
   logic              timed_out;
   logic [2:0]        eff_phase;
   logic [TIME_W-1:0] gap;
   logic [IDX_W-1:0]  index_inc;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;

   assign gap       = now_ms - last_time_ff;
   assign timed_out = gap > {{(TIME_W-TMO_W){1'b0}}, cfg.timeout_ms};
   assign eff_phase = timed_out ? PH_WAIT : phase_ff;
   assign index_inc = index_ff + IDX_W'(1);

   always_comb begin
      phase_in   = eff_phase;
      command_in = command_ff;
      length_in  = length_ff;
      index_in   = timed_out ? '0 : index_ff;
      xor_in     = xor_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      frame_push = 1'b0;
      unique case (eff_phase)
         PH_CMD: begin
            command_in = rx_byte;
            xor_in     = xor_ff ^ rx_byte;
            phase_in   = PH_LEN;
         end
         PH_LEN: begin
            xor_in = xor_ff ^ rx_byte;
            // lengths above the limit are never used, so only the low bits stay
            length_in = rx_byte[IDX_W-1:0];
            if (rx_byte == '0) begin
               phase_in = PH_SUM;
            end else if (rx_byte <= BYTE_W'(MAX_DATA)) begin
               phase_in = PH_DATA;
               index_in = '0;
            end else begin
               phase_in = PH_WAIT;
            end
         end
         PH_DATA: begin
            xor_in   = xor_ff ^ rx_byte;
            index_in = index_inc;
            if (index_ff == IDX_W'(0)) begin
               first_in = rx_byte;
            end
            if (index_ff == IDX_W'(1)) begin
               second_in = rx_byte;
            end
            if (index_inc >= length_ff) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            frame_push = accept;
            phase_in   = PH_WAIT;
         end
         default: begin
            phase_in = PH_WAIT;
            if (rx_byte == cfg.start_byte) begin
               phase_in = PH_CMD;
               index_in = '0;
               xor_in   = rx_byte;
            end
         end
      endcase
   end

   always_comb begin
      frame.sum_ok      = (rx_byte == xor_ff);
      frame.two_data    = (length_ff >= IDX_W'(2));
      frame.command     = command_ff;
      frame.first_data  = first_ff;
      frame.second_data = second_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         command_ff   <= '0;
         length_ff    <= '0;
         index_ff     <= '0;
         xor_ff       <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         last_time_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         command_ff   <= command_in;
         length_ff    <= length_in;
         index_ff     <= index_in;
         xor_ff       <= xor_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         last_time_ff <= now_ms;
      end
   end

endmodule

// ===== rtl/xfcp_queue.sv =====
// ----------------------------------------------------------------------------
// xfcp_queue: short frame queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module xfcp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  xfcp_pkg::frame_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output xfcp_pkg::frame_type pop_data
);
   import xfcp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== rtl/xfcp_back.sv =====
// ----------------------------------------------------------------------------
// xfcp_back: command decoder and result register
// Pops a frame, resolves status and action, and holds the result until taken.
// ----------------------------------------------------------------------------
module xfcp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  xfcp_pkg::cfg_type             cfg,
   input  logic                          frame_avail,
   input  xfcp_pkg::frame_type           frame,
   output logic                          frame_pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [xfcp_pkg::STATUS_W-1:0] status,
   output logic [xfcp_pkg::ACTION_W-1:0] action,
   output logic [xfcp_pkg::BYTE_W-1:0]   volume,
   output logic [xfcp_pkg::BYTE_W-1:0]   duration
);
   import xfcp_pkg::*;

   logic                valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [BYTE_W-1:0]   volume_ff, volume_in;
   logic [BYTE_W-1:0]   duration_ff, duration_in;

   assign frame_pop = frame_avail && (!valid_ff || out_ready);

   // first matching code wins
   always_comb begin
      status_in   = ST_OK;
      action_in   = ACT_NONE;
      volume_in   = '0;
      duration_in = '0;
      priority if (!frame.sum_ok) begin
         status_in = ST_BAD_SUM;
      end else if (frame.command == cfg.code_green) begin
         action_in = ACT_GREEN;
      end else if (frame.command == cfg.code_yellow) begin
         action_in = ACT_YELLOW;
      end else if (frame.command == cfg.code_red) begin
         action_in = ACT_RED;
      end else if (frame.command == cfg.code_off) begin
         action_in = ACT_OFF;
      end else if (frame.command == cfg.code_buzzer) begin
         if (frame.two_data) begin
            action_in   = ACT_BUZZER;
            volume_in   = frame.first_data;
            duration_in = frame.second_data;
         end else begin
            status_in = ST_SHORT_BUZ;
         end
      end else begin
         status_in = ST_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (frame_pop) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_pop) begin
         status_ff   <= status_in;
         action_ff   <= action_in;
         volume_ff   <= volume_in;
         duration_ff <= duration_in;
      end
   end

   assign out_valid = valid_ff;
   assign status    = status_ff;
   assign action    = action_ff;
   assign volume    = volume_ff;
   assign duration  = duration_ff;

endmodule

// ===== rtl/xor_framed_command_parser.sv =====
// ----------------------------------------------------------------------------
// xor_framed_command_parser: framed serial command parser with XOR checksum
// Parses start, command, length, data, checksum frames and decodes the
// command into a light or buzzer action with a status.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                              accepted when
//   req_bus   in         rx_byte[7:0], now_ms[31:0]           valid && ready
//   rsp_bus   out        status[1:0], action[2:0],            valid && ready
//                        volume[7:0], duration[7:0]
//   csr_bus   in         index[2:0], data[15:0]               valid && ready
//
// One byte per cycle enters while the frame queue has room; a checksum
// byte's result passes through the frame queue and then the decode
// register behind it.
// Reset returns all registers to their defaults and the parser to hunting.
// A stalled result is held in the output register; the two-entry frame
// queue keeps bytes flowing until it fills, then req_bus.ready drops.
// csr_bus is always ready.
//
module xor_framed_command_parser #(
   parameter int MAX_DATA = xfcp_pkg::MAX_DATA_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   xfcp_req_if.sink          req_bus,
   xfcp_rsp_if.source        rsp_bus,
   xfcp_csr_if.sink          csr_bus
);
   import xfcp_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   frame_type front_frame;
   frame_type queue_frame;
   logic      frame_push;
   logic      frame_pop;
   logic      queue_full;
   logic      queue_avail;

   // register file: the user must write only while the parser is idle; not enforced here
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      unique case (csr_bus.index)
         REG_START_BYTE:  cfg_in.start_byte  = csr_bus.data[BYTE_W-1:0];
         REG_TIMEOUT_MS:  cfg_in.timeout_ms  = csr_bus.data[TMO_W-1:0];
         REG_CODE_GREEN:  cfg_in.code_green  = csr_bus.data[BYTE_W-1:0];
         REG_CODE_YELLOW: cfg_in.code_yellow = csr_bus.data[BYTE_W-1:0];
         REG_CODE_RED:    cfg_in.code_red    = csr_bus.data[BYTE_W-1:0];
         REG_CODE_OFF:    cfg_in.code_off    = csr_bus.data[BYTE_W-1:0];
         REG_CODE_BUZZER: cfg_in.code_buzzer = csr_bus.data[BYTE_W-1:0];
         default:         cfg_in = cfg_ff;  // drop writes to unmapped indexes
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: timeout, phase tracking, running XOR
   xfcp_front #(
      .MAX_DATA (MAX_DATA)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .byte_valid (req_bus.valid),
      .byte_ready (req_bus.ready),
      .rx_byte    (req_bus.rx_byte),
      .now_ms     (req_bus.now_ms),
      .queue_full (queue_full),
      .frame_push (frame_push),
      .frame      (front_frame)
   );

   // hold completed frames while the result side stalls
   xfcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (front_frame),
      .full      (queue_full),
      .pop       (frame_pop),
      .not_empty (queue_avail),
      .pop_data  (queue_frame)
   );

   // back end: command decode and result register
   xfcp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .frame_avail (queue_avail),
      .frame       (queue_frame),
      .frame_pop   (frame_pop),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .status      (rsp_bus.status),
      .action      (rsp_bus.action),
      .volume      (rsp_bus.volume),
      .duration    (rsp_bus.duration)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the framed command parser
// Feeds timestamped serial bytes (well-formed frames, broken frames and line
// noise) under six register settings, predicts every decoded command from a
// behavioral copy of the parser and compares each result field by field.
// ----------------------------------------------------------------------------
module testbench;
   import xfcp_pkg::*;

   localparam int FRAME_MAX       = MAX_DATA_DEFAULT;
   localparam int SETTLE_CYCLES   = 16;      // generous for decode plus frame queue
   localparam int LONG_HOLD       = 200;     // long receiver stall, in cycles
   localparam int DRAIN_LIMIT     = 20000;   // bound on the final wait for results
   localparam int WATCHDOG_NS     = 4000000; // bound on the whole run, in ns
   localparam int PRINT_CAP       = 40;      // stop printing mismatches after this
   localparam int SETTINGS_RUN    = 6;

   // register index with no register behind it: writes must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum logic [2:0] {
      HUNT_START, TAKE_CMD, TAKE_LEN, TAKE_DATA, TAKE_SUM
   } parse_phase_type;

   // one received byte as the sender will offer it
   typedef struct packed {
      logic              drain_first; // hold until every pending result is back
      logic [3:0]        gap;         // idle cycles before offering
      logic [BYTE_W-1:0] rx_byte;
      logic [TIME_W-1:0] now_ms;
   } rx_item_type;

   // one decoded command as it should leave the block
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   volume;
      logic [BYTE_W-1:0]   duration;
   } action_rec_type;

   logic clock = 1'b0;
   logic reset;

   xfcp_req_if req_bus ();
   xfcp_rsp_if rsp_bus ();
   xfcp_csr_if csr_bus ();

   xor_framed_command_parser #(.MAX_DATA(FRAME_MAX)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   // --------------------------------------------------------------------------
   // Shared bench state
   // --------------------------------------------------------------------------
   rx_item_type    rx_stream[$];        // bytes waiting to be offered
   action_rec_type expected_actions[$]; // decoded commands still owed by the block

   int          errors        = 0;
   int          bytes_taken   = 0;
   int          results_seen  = 0;
   int          status_seen[4];
   logic [31:0] stamp_ms;            // timestamp of the last queued byte
   int          send_gap_max  = 0;
   int          rsp_stall_max = 0;
   int          holds_asked   = 0;
   int          holds_served  = 0;
   bit          req_taken     = 1'b0; // set at the rising edge, read at the falling
   bit          rsp_taken     = 1'b0;

   // --------------------------------------------------------------------------
   // Parser copy: registers and frame state as the block should hold them
   // --------------------------------------------------------------------------
   cfg_type           regs;
   parse_phase_type   fr_phase;
   logic [BYTE_W-1:0] fr_cmd;
   logic [BYTE_W-1:0] fr_len;
   logic [BYTE_W-1:0] fr_idx;
   logic [BYTE_W-1:0] fr_xor;
   logic [BYTE_W-1:0] fr_d0;
   logic [BYTE_W-1:0] fr_d1;
   logic [TIME_W-1:0] fr_last_ms;

   // Advance the parser copy by one accepted byte; queue a result when the
   // checksum byte closes a frame.
   task automatic parse_rx_byte(input logic [BYTE_W-1:0] rx, input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] gap;
      action_rec_type    res;
      gap = now - fr_last_ms;
      // a gap beyond the timeout abandons the frame before this byte counts
      if (gap > {16'h0000, regs.timeout_ms}) begin
         fr_phase = HUNT_START;
         fr_idx   = '0;
      end
      fr_last_ms = now;
      case (fr_phase)
         TAKE_CMD: begin
            fr_cmd   = rx;
            fr_xor   = fr_xor ^ rx;
            fr_phase = TAKE_LEN;
         end
         TAKE_LEN: begin
            fr_len = rx;
            fr_xor = fr_xor ^ rx;
            if (rx == '0) begin
               fr_phase = TAKE_SUM;
            end else if (rx <= FRAME_MAX) begin
               fr_phase = TAKE_DATA;
               fr_idx   = '0;
            end else begin
               fr_phase = HUNT_START; // oversized frame: drop silently
            end
         end
         TAKE_DATA: begin
            fr_xor = fr_xor ^ rx;
            if (fr_idx == 8'd0) begin
               fr_d0 = rx;
            end else if (fr_idx == 8'd1) begin
               fr_d1 = rx;
            end
            fr_idx = fr_idx + 8'd1;
            if (fr_idx >= fr_len) fr_phase = TAKE_SUM;
         end
         TAKE_SUM: begin
            res.status   = ST_OK;
            res.action   = ACT_NONE;
            res.volume   = '0;
            res.duration = '0;
            // first matching code wins when registers overlap
            if (rx != fr_xor) begin
               res.status = ST_BAD_SUM;
            end else if (fr_cmd == regs.code_green) begin
               res.action = ACT_GREEN;
            end else if (fr_cmd == regs.code_yellow) begin
               res.action = ACT_YELLOW;
            end else if (fr_cmd == regs.code_red) begin
               res.action = ACT_RED;
            end else if (fr_cmd == regs.code_off) begin
               res.action = ACT_OFF;
            end else if (fr_cmd == regs.code_buzzer) begin
               if (fr_len >= 8'd2) begin
                  res.action   = ACT_BUZZER;
                  res.volume   = fr_d0;
                  res.duration = fr_d1;
               end else begin
                  res.status = ST_SHORT_BUZ;
               end
            end else begin
               res.status = ST_UNKNOWN;
            end
            expected_actions.push_back(res);
            fr_phase = HUNT_START;
         end
         default: begin
            fr_phase = HUNT_START;
            if (rx == regs.start_byte) begin
               fr_phase = TAKE_CMD;
               fr_idx   = '0;
               fr_xor   = rx;
            end
         end
      endcase
   endtask

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // --------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge. Check the result first
   // so a spurious result can never consume an expectation pushed this cycle.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      action_rec_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_taken = 1'b1;
            if (expected_actions.size() == 0) begin
               errors++;
               if (errors <= PRINT_CAP)
                  $display("%0t: spurious result, expected none, actual status %0d action %0d",
                           $time, rsp_bus.status, rsp_bus.action);
            end else begin
               want = expected_actions.pop_front();
               compare_field("status", 8'(want.status), 8'(rsp_bus.status));
               compare_field("action", 8'(want.action), 8'(rsp_bus.action));
               compare_field("volume", want.volume, rsp_bus.volume);
               compare_field("duration", want.duration, rsp_bus.duration);
               status_seen[want.status]++;
               results_seen++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1'b1;
            bytes_taken++;
            parse_rx_byte(req_bus.rx_byte, req_bus.now_ms);
         end
      end
   end

   // --------------------------------------------------------------------------
   // Driver: at the falling edge drop a taken transaction, burn the item's
   // idle gap, then offer the next byte. Valid gets one assignment per step.
   // --------------------------------------------------------------------------
   int send_wait = 0;

   always @(negedge clock) begin
      rx_item_type item;
      logic        offer;
      offer = req_bus.valid;
      if (req_taken) offer = 1'b0;
      if (!offer && !reset) begin
         if (send_wait > 0) begin
            send_wait--;
         end else if (rx_stream.size() != 0 &&
                      (!rx_stream[0].drain_first || expected_actions.size() == 0)) begin
            if (rx_stream[0].gap != 0) begin
               send_wait = rx_stream[0].gap - 1;
               rx_stream[0].gap = '0;
            end else begin
               item = rx_stream.pop_front();
               req_bus.rx_byte <= item.rx_byte;
               req_bus.now_ms  <= item.now_ms;
               offer = 1'b1;
            end
         end
      end
      req_bus.valid <= offer;
   end

   // --------------------------------------------------------------------------
   // Receiver: stall a random number of cycles after each result, and hold
   // off for a long stretch whenever the stimulus asks for it.
   // --------------------------------------------------------------------------
   int stall_left = 0;
   int hold_left  = 0;

   always @(negedge clock) begin
      if (rsp_taken) stall_left = $urandom_range(0, rsp_stall_max);
      if (holds_served < holds_asked) begin
         hold_left = LONG_HOLD;
         holds_served++;
      end
      rsp_bus.ready <= (hold_left == 0 && stall_left == 0);
      if (hold_left > 0) begin
         hold_left--;
      end else if (stall_left > 0) begin
         stall_left--;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] b, input logic [31:0] step, input bit drain);
      rx_item_type item;
      stamp_ms         = stamp_ms + step;
      item.drain_first = drain;
      item.gap         = 4'($urandom_range(0, send_gap_max));
      item.rx_byte     = b;
      item.now_ms      = stamp_ms;
      rx_stream.push_back(item);
   endtask

   // Mostly stay inside the timeout; now and then land exactly on it, just
   // past it, or anywhere in the 32-bit range (wrap and backward jumps).
   function automatic logic [31:0] pick_step();
      int unsigned sel;
      logic [31:0] tmo;
      sel = $urandom_range(0, 99);
      tmo = {16'h0000, regs.timeout_ms};
      if (sel < 1) return tmo + 32'd1;
      if (sel < 3) return tmo;
      if (sel < 4) return $urandom();
      return $urandom_range(0, tmo);
   endfunction

   // Queue one frame. Data bytes beyond the first two are random; an
   // oversized length stops after the length byte.
   task automatic queue_frame(input logic [7:0] cmd, input int len, input bit good_sum,
                              input logic [7:0] d0, input logic [7:0] d1,
                              input logic [31:0] lead, input bit rand_steps,
                              input bit drain);
      logic [7:0] sum;
      logic [7:0] b;
      sum = regs.start_byte ^ cmd ^ 8'(len);
      queue_byte(regs.start_byte, lead, drain);
      queue_byte(cmd, rand_steps ? pick_step() : 32'd0, 1'b0);
      queue_byte(8'(len), rand_steps ? pick_step() : 32'd0, 1'b0);
      if (len > FRAME_MAX) return;
      for (int i = 0; i < len; i++) begin
         b   = (i == 0) ? d0 : (i == 1) ? d1 : 8'($urandom);
         sum = sum ^ b;
         queue_byte(b, rand_steps ? pick_step() : 32'd0, 1'b0);
      end
      if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
      queue_byte(sum, rand_steps ? pick_step() : 32'd0, 1'b0);
   endtask

   // Mostly well-formed frames with random content, the rest line noise.
   task automatic queue_random_traffic(input int target, input bit pause_once);
      int          goal;
      int          sel;
      int          len;
      logic [7:0]  cmd;
      bit          drain;
      goal = rx_stream.size() + target;
      while (rx_stream.size() < goal) begin
         sel = $urandom_range(0, 99);
         if (sel < 15) begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), pick_step(), 1'b0);
         end else begin
            case ($urandom_range(0, 5))
               0:       cmd = regs.code_green;
               1:       cmd = regs.code_yellow;
               2:       cmd = regs.code_red;
               3:       cmd = regs.code_off;
               4:       cmd = regs.code_buzzer;
               default: cmd = 8'($urandom);
            endcase
            sel = $urandom_range(0, 99);
            if (sel < 15)      len = 0;
            else if (sel < 30) len = 1;
            else if (sel < 70) len = 2;
            else if (sel < 86) len = $urandom_range(3, 6);
            else if (sel < 92) len = $urandom_range(7, FRAME_MAX);
            else if (sel < 95) len = FRAME_MAX;
            else               len = $urandom_range(FRAME_MAX + 1, 255);
            // hold one frame back until everything before it has drained
            drain = pause_once && (rx_stream.size() >= goal - target / 2);
            if (drain) pause_once = 1'b0;
            queue_frame(cmd, len, $urandom_range(0, 99) < 85, 8'($urandom), 8'($urandom),
                        pick_step(), 1'b1, drain);
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_START_BYTE:  regs.start_byte  = val[7:0];
         REG_TIMEOUT_MS:  regs.timeout_ms  = val;
         REG_CODE_GREEN:  regs.code_green  = val[7:0];
         REG_CODE_YELLOW: regs.code_yellow = val[7:0];
         REG_CODE_RED:    regs.code_red    = val[7:0];
         REG_CODE_OFF:    regs.code_off    = val[7:0];
         REG_CODE_BUZZER: regs.code_buzzer = val[7:0];
         default: ; // unmapped index: write ignored
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Write all seven registers; junk in the upper bits of the byte-wide ones
   // must be dropped by the block.
   task automatic set_regs(input logic [7:0] sb, input logic [15:0] tmo, input logic [7:0] g,
                           input logic [7:0] y, input logic [7:0] r, input logic [7:0] o,
                           input logic [7:0] bz);
      write_reg(REG_START_BYTE,  {8'($urandom), sb});
      write_reg(REG_TIMEOUT_MS,  tmo);
      write_reg(REG_CODE_GREEN,  {8'($urandom), g});
      write_reg(REG_CODE_YELLOW, {8'($urandom), y});
      write_reg(REG_CODE_RED,    {8'($urandom), r});
      write_reg(REG_CODE_OFF,    {8'($urandom), o});
      write_reg(REG_CODE_BUZZER, {8'($urandom), bz});
   endtask

   // Wait until the sender is empty and every result is back, then let the
   // block settle so no byte without a result is still in flight.
   task automatic wait_quiet();
      while (rx_stream.size() != 0 || req_bus.valid || expected_actions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      int         phase_len;
      logic [7:0] shared_code;

      reset         = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      req_bus.now_ms  = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;

      regs       = CFG_RESET;
      fr_phase   = HUNT_START;
      fr_cmd     = '0;
      fr_len     = '0;
      fr_idx     = '0;
      fr_xor     = '0;
      fr_d0      = '0;
      fr_d1      = '0;
      fr_last_ms = '0;
      // start close to the top so timestamps wrap early in the run
      stamp_ms   = 32'hFFFF_FFF0;
      for (int s = 0; s < 4; s++) status_seen[s] = 0;

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      for (int p = 0; p < SETTINGS_RUN; p++) begin
         // pick the register setting and the idling for this stretch
         case (p)
            0: begin
               send_gap_max  = 3;
               rsp_stall_max = 3;
            end
            1: begin
               // all-low extremes, zero timeout, green and yellow overlap
               set_regs(8'h00, 16'h0000, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F);
               send_gap_max  = 0;
               rsp_stall_max = 0;
            end
            2: begin
               set_regs(8'hFF, 16'hFFFF, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hFF);
               write_reg(REG_UNUSED, 16'($urandom));
               send_gap_max  = 2;
               rsp_stall_max = 8;
            end
            5: begin
               // off and buzzer share a code: off must win
               shared_code = 8'($urandom);
               set_regs(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), shared_code, shared_code);
               send_gap_max  = $urandom_range(1, 8);
               rsp_stall_max = $urandom_range(1, 8);
            end
            default: begin
               set_regs(8'($urandom), 16'($urandom_range(0, 400)), 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
               send_gap_max  = $urandom_range(1, 8);
               rsp_stall_max = $urandom_range(1, 8);
            end
         endcase

         if (p == 0) begin
            // frame cut by a gap; the start byte after the gap opens a new one
            queue_byte(regs.start_byte, 32'd0, 1'b0);
            queue_byte(regs.code_yellow, 32'd0, 1'b0);
            queue_frame(regs.code_green, 0, 1'b1, 8'h00, 8'h00,
                        {16'h0000, regs.timeout_ms} + 32'd1, 1'b0, 1'b0);
            // buzzer with extreme payload and one extra data byte
            queue_frame(regs.code_buzzer, 3, 1'b1, 8'hFF, 8'h00, 32'd0, 1'b0, 1'b0);
            // buzzer with a single data byte: too short
            queue_frame(regs.code_buzzer, 1, 1'b1, 8'h5A, 8'h00, 32'd0, 1'b0, 1'b0);
            queue_frame(regs.code_yellow, 0, 1'b0, 8'h00, 8'h00, 32'd0, 1'b0, 1'b0);
            queue_frame(8'h77, 0, 1'b1, 8'h00, 8'h00, 32'd0, 1'b0, 1'b0);
            // length one past the limit: abort without a result
            queue_frame(regs.code_red, FRAME_MAX + 1, 1'b1, 8'h00, 8'h00, 32'd0, 1'b0, 1'b0);
         end

         queue_random_traffic(p == 0 ? 220 : 240, p == 4);

         if (p == 2) begin
            // hold the receiver while bytes keep flowing so the block backs up
            phase_len = rx_stream.size();
            while (rx_stream.size() > phase_len - 30) @(posedge clock);
            holds_asked++;
         end

         wait_quiet();
      end

      // all stimulus taken: wait out the last results, bounded
      while (rx_stream.size() != 0 || req_bus.valid) @(posedge clock);
      for (int n = 0; n < DRAIN_LIMIT && expected_actions.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_actions.size() != 0) begin
         errors += expected_actions.size();
         $display("%0t: %0d expected results never arrived", $time, expected_actions.size());
      end

      $display("Run covered %0d received bytes over %0d register settings, %0d results checked.",
               bytes_taken, SETTINGS_RUN, results_seen);
      $display("Results by status: ok %0d, bad sum %0d, unknown command %0d, short buzzer %0d.",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog: a hung handshake ends the run as a failure
   initial begin
      #(WATCHDOG_NS);
      $display("%0t: watchdog expired, run did not finish", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
